// File: hdl/alutrb_pkg.sv
// shared types, constants and opcodes of the alu with tagged result buffer
`timescale 1ns / 1ps
`default_nettype none

package alutrb_pkg;

    // default sizes
    localparam int unsigned BUFFER_SLOTS_DEF = 4;
    localparam int unsigned ROB_DEPTH_DEF    = 32;

    // field widths
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned TAG_W   = 5;
    localparam int unsigned OP_W    = 4;
    localparam int unsigned SHAMT_W = 5;
    localparam int unsigned TAG_NUM = 2 ** TAG_W;

    localparam logic [DATA_W-1:0]  JUMP_MASK  = 32'hFFFF_FFFE;
    localparam logic [SHAMT_W-1:0] SHAMT_MASK = 5'h1F;

    // alu opcodes, codes above jump give zero
    typedef enum logic [OP_W-1:0] {
        ALU_ADD   = 4'd0,
        ALU_AUIPC = 4'd1,
        ALU_SUB   = 4'd2,
        ALU_XOR   = 4'd3,
        ALU_OR    = 4'd4,
        ALU_AND   = 4'd5,
        ALU_SLL   = 4'd6,
        ALU_SRL   = 4'd7,
        ALU_SRA   = 4'd8,
        ALU_SLT   = 4'd9,
        ALU_SLTU  = 4'd10,
        ALU_LUI   = 4'd11,
        ALU_JUMP  = 4'd12
    } t_alu_op;

    // input word
    typedef struct packed {
        logic              dispatch_valid;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [OP_W-1:0]   alu_op;
        logic [TAG_W-1:0]  dispatch_tag;
        logic              writeback_valid;
        logic [TAG_W-1:0]  writeback_tag;
        logic              squash_valid;
        logic [TAG_W-1:0]  squash_tag;
        logic [TAG_W-1:0]  rob_head;
    } t_alu_in;

    // output word
    typedef struct packed {
        logic              head_valid;
        logic [DATA_W-1:0] head_value;
        logic [TAG_W-1:0]  head_tag;
        logic              head_is_control;
        logic              buffer_full;
        logic              buffer_empty;
    } t_alu_out;

endpackage

`default_nettype wire

// File: hdl/alutrb_if.sv
// valid/ready channel carrying one word of a given payload type
`timescale 1ns / 1ps
`default_nettype none

interface alutrb_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/alu_with_tagged_result_buffer_top.sv
// rv32i alu feeding a small tagged result buffer with writeback, squash and head report
// the result word for an input word is shown in the cycle after it is accepted
// throughput: one word per cycle unless the sink stalls; alu, slot update and oldest-slot search sit
//   between the slot registers and the output register in a single pass
// input ready stays high unless a finished result waits and the sink stalls
// reset (synchronous, active low): all slots empty, no result pending
`timescale 1ns / 1ps
`default_nettype none

module alu_with_tagged_result_buffer_top #(
    parameter int unsigned BUFFER_SLOTS = alutrb_pkg::BUFFER_SLOTS_DEF,
    parameter int unsigned ROB_DEPTH    = alutrb_pkg::ROB_DEPTH_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    alutrb_if.sink   i_in,
    alutrb_if.source o_out
);
    import alutrb_pkg::*;

    localparam int unsigned SW = BUFFER_SLOTS;
    localparam int unsigned AW = $clog2(ROB_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(ROB_DEPTH);

    t_alu_in             w_in;
    logic                w_in_ready;
    logic                w_accept;

    // slot storage
    logic [SW-1:0]       r_slot_valid;
    logic [DATA_W-1:0]   r_slot_value [SW];
    logic [TAG_W-1:0]    r_slot_tag   [SW];
    logic                r_slot_ctrl  [SW];

    // output register
    logic                r_out_valid;
    t_alu_out            r_out;
    t_alu_out            n_out;

    // per-step working signals
    logic [AW-1:0]       w_mod_tbl [TAG_NUM];
    logic [DATA_W-1:0]   w_alu_res;
    logic                w_alu_ctrl;
    logic [SW-1:0]       w_free;
    logic [SW-1:0]       w_disp_oh;
    logic [DATA_W-1:0]   w_value [SW];
    logic [TAG_W-1:0]    w_tag   [SW];
    logic                w_ctrl  [SW];
    logic [AW-1:0]       w_age   [SW];
    logic [AW-1:0]       w_sq_age;
    logic [SW-1:0]       w_v1;
    logic [SW-1:0]       w_wb_match;
    logic [SW-1:0]       w_wb_oh;
    logic [SW-1:0]       w_v2;
    logic [SW-1:0]       n_slot_valid;
    logic [SW-1:0]       w_head_oh;

    // distance from the rob head, both operands already reduced
    function automatic logic [AW-1:0] f_age(input logic [AW-1:0] tm,
                                            input logic [AW-1:0] hm);
        logic [AW:0] diff;
        if (tm >= hm) begin
            diff = {1'b0, tm} - {1'b0, hm};
        end else begin
            diff = {1'b0, tm} + DEPTH_W - {1'b0, hm};
        end
        return diff[AW-1:0];
    endfunction

    // rv32i integer operations
    function automatic logic [DATA_W-1:0] f_alu(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b,
                                                input logic [OP_W-1:0]   op);
        logic [SHAMT_W-1:0] sh;
        logic [DATA_W-1:0]  res;
        sh = b[SHAMT_W-1:0] & SHAMT_MASK;
        unique case (op)
            ALU_ADD, ALU_AUIPC: res = a + b;
            ALU_SUB:            res = a - b;
            ALU_XOR:            res = a ^ b;
            ALU_OR:             res = a | b;
            ALU_AND:            res = a & b;
            ALU_SLL:            res = a << sh;
            ALU_SRL:            res = a >> sh;
            ALU_SRA:            res = $unsigned($signed(a) >>> sh);
            ALU_SLT:            res = DATA_W'($signed(a) < $signed(b));
            ALU_SLTU:           res = DATA_W'(a < b);
            ALU_LUI:            res = b;
            ALU_JUMP:           res = (a + b) & JUMP_MASK;
            default:            res = '0;
        endcase
        return res;
    endfunction

    // tag modulo rob depth, built at elaboration
    for (genvar g = 0; g < TAG_NUM; g++) begin : g_mod
        localparam int unsigned TagMod = g % ROB_DEPTH;
        assign w_mod_tbl[g] = AW'(TagMod);
    end

    // handshake
    assign w_in       = i_in.payload;
    assign w_in_ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // alu
    assign w_alu_res  = f_alu(w_in.operand_a, w_in.operand_b, w_in.alu_op);
    assign w_alu_ctrl = (w_in.alu_op == ALU_JUMP);

    // lowest free slot takes the dispatch, none when full
    always_comb begin
        w_free    = ~r_slot_valid;
        w_disp_oh = w_in.dispatch_valid ? (w_free & ((~w_free) + SW'(1))) : '0;
        w_v1      = r_slot_valid | w_disp_oh;
    end

    // slot contents after dispatch, and their ages
    always_comb begin
        for (int i = 0; i < SW; i++) begin
            w_value[i] = w_disp_oh[i] ? w_alu_res     : r_slot_value[i];
            w_tag[i]   = w_disp_oh[i] ? w_in.dispatch_tag : r_slot_tag[i];
            w_ctrl[i]  = w_disp_oh[i] ? w_alu_ctrl    : r_slot_ctrl[i];
            w_age[i]   = f_age(w_mod_tbl[w_tag[i]], w_mod_tbl[w_in.rob_head]);
        end
        w_sq_age = f_age(w_mod_tbl[w_in.squash_tag], w_mod_tbl[w_in.rob_head]);
    end

    // writeback frees the lowest matching slot
    always_comb begin
        for (int i = 0; i < SW; i++) begin
            w_wb_match[i] = w_in.writeback_valid && w_v1[i]
                            && (w_tag[i] == w_in.writeback_tag);
        end
        w_wb_oh = w_wb_match & ((~w_wb_match) + SW'(1));
        w_v2    = w_v1 & ~w_wb_oh;
    end

    // squash clears every slot not older than the boundary
    always_comb begin
        for (int i = 0; i < SW; i++) begin
            n_slot_valid[i] = w_v2[i] && !(w_in.squash_valid && (w_age[i] >= w_sq_age));
        end
    end

    // oldest slot, ties go to the lower index
    always_comb begin
        for (int i = 0; i < SW; i++) begin
            w_head_oh[i] = n_slot_valid[i];
            for (int j = 0; j < SW; j++) begin
                if (j < i && n_slot_valid[j] && !(w_age[i] < w_age[j])) begin
                    w_head_oh[i] = 1'b0;
                end
                if (j > i && n_slot_valid[j] && (w_age[j] < w_age[i])) begin
                    w_head_oh[i] = 1'b0;
                end
            end
        end
    end

    // result word
    always_comb begin
        n_out = '0;
        for (int i = 0; i < SW; i++) begin
            if (w_head_oh[i]) begin
                n_out.head_value      = n_out.head_value | w_value[i];
                n_out.head_tag        = n_out.head_tag | w_tag[i];
                n_out.head_is_control = n_out.head_is_control | w_ctrl[i];
            end
        end
        n_out.head_valid   = |n_slot_valid;
        n_out.buffer_full  = &n_slot_valid;
        n_out.buffer_empty = ~|n_slot_valid;
    end

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (w_accept) begin
            r_slot_valid <= n_slot_valid;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SW; i++) begin
            if (w_accept && w_disp_oh[i]) begin
                r_slot_value[i] <= w_alu_res;
                r_slot_tag[i]   <= w_in.dispatch_tag;
                r_slot_ctrl[i]  <= w_alu_ctrl;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// File: hdl/alutrb_checker.sv
// port-level checks of the alu result buffer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module alutrb_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_in_valid,
    input wire                       i_in_ready,
    input wire                       i_out_valid,
    input wire                       i_out_ready,
    input wire alutrb_pkg::t_alu_out i_out_payload
);
    import alutrb_pkg::*;

    // input side only stalls while a result waits
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with output free");

    // every accepted word leaves a result word behind
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted word produced no result");

    // head valid agrees with the empty flag
    a_head_vs_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_payload.head_valid != i_out_payload.buffer_empty))
        else $error("head valid and empty flag disagree");

    // empty buffer reports a zero head
    a_empty_zero_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_payload.head_valid) |->
        (i_out_payload.head_value == '0 && i_out_payload.head_tag == '0
         && !i_out_payload.head_is_control && !i_out_payload.buffer_full))
        else $error("empty buffer with nonzero head");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)))
        else $error("stalled output word changed");

endmodule

bind alu_with_tagged_result_buffer_top alutrb_checker u_alutrb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

`default_nettype wire
